[sv/ggig_pkg.sv]
// Shared constants and types for the grid ghost index generator.
`timescale 1ns / 1ps

package ggig_pkg;

	// Default geometry of the walk.
	localparam int MAX_DIMS_DEF   = 4;
	localparam int COORD_BITS_DEF = 12;

	// Fixed field widths.
	localparam int INDEX_W   = 48;
	localparam int SIZE_W    = 13;
	localparam int DIMS_W    = 3;
	localparam int SIZE_REGS = 4;
	localparam int CFG_W     = SIZE_W;
	localparam int ADDR_W    = 3;

	// Register indexes on the configuration port.
	typedef enum logic [ADDR_W-1:0] {
		CFG_NUM_DIMS   = 3'd0,
		CFG_DIM_SIZE_0 = 3'd1,
		CFG_DIM_SIZE_1 = 3'd2,
		CFG_DIM_SIZE_2 = 3'd3,
		CFG_DIM_SIZE_3 = 3'd4
	} cfg_addr_t;

	localparam logic [DIMS_W-1:0] NUM_DIMS_RST = 3'd3;
	localparam logic [SIZE_W-1:0] DIM_SIZE_RST = 13'd256;

	// Status of the current grid point, from the step logic to the top level.
	typedef struct packed {
		logic boundary;
		logic final_pt;
	} step_status_t;

endpackage

[sv/ggig_step.sv]
// Boundary test and mixed-radix advance of the grid coordinate counters.
`timescale 1ns / 1ps

module ggig_step #(
	parameter int MAX_DIMS   = ggig_pkg::MAX_DIMS_DEF,
	parameter int COORD_BITS = ggig_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0]          cnt [MAX_DIMS],
	input  logic [ggig_pkg::DIMS_W-1:0]    num_dims,
	input  logic [ggig_pkg::SIZE_W-1:0]    dim_size [ggig_pkg::SIZE_REGS],
	output logic [COORD_BITS-1:0]          cnt_next [MAX_DIMS],
	output ggig_pkg::step_status_t         status
);
	import ggig_pkg::*;

	localparam int DIM_LIM = (MAX_DIMS < SIZE_REGS) ? MAX_DIMS : SIZE_REGS;
	localparam int CMP_W   = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
	localparam logic [CMP_W-1:0] END_LIM = CMP_W'((64'd1 << COORD_BITS) - 64'd1);

	logic [DIMS_W-1:0]   nd;
	logic [MAX_DIMS-1:0] in_use;
	logic [MAX_DIMS-1:0] at_end;
	logic [MAX_DIMS-1:0] at_zero;

	// A num_dims of zero means one dimension; large values saturate.
	always_comb begin
		priority if (num_dims == '0) begin
			nd = DIMS_W'(1);
		end else if (num_dims > DIMS_W'(DIM_LIM)) begin
			nd = DIMS_W'(DIM_LIM);
		end else begin
			nd = num_dims;
		end
	end

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
		logic [SIZE_W-1:0] end_raw;
		logic [CMP_W-1:0]  end_ext;
		logic [CMP_W-1:0]  end_sat;

		// Last coordinate of the dimension: size minus one, clamped to the counter range.
		assign end_raw   = (dim_size[d % SIZE_REGS] == '0) ? '0
			: dim_size[d % SIZE_REGS] - SIZE_W'(1);
		assign end_ext   = CMP_W'(end_raw);
		assign end_sat   = (end_ext > END_LIM) ? END_LIM : end_ext;
		assign at_end[d] = CMP_W'(cnt[d]) >= end_sat;
		assign at_zero[d] = (cnt[d] == '0);
		assign in_use[d] = (d < int'(nd));
	end

	always_comb begin
		logic carry;
		logic bnd;
		logic fin;
		carry = 1'b1;
		bnd   = 1'b0;
		fin   = 1'b1;
		for (int d = 0; d < MAX_DIMS; d++) begin
			cnt_next[d] = cnt[d];
			if (in_use[d]) begin
				if (at_zero[d] || at_end[d]) begin
					bnd = 1'b1;
				end
				if (!at_end[d]) begin
					fin = 1'b0;
				end
				if (carry) begin
					if (at_end[d]) begin
						cnt_next[d] = '0;
					end else begin
						cnt_next[d] = cnt[d] + COORD_BITS'(1);
						carry = 1'b0;
					end
				end
			end
		end
		// The final point wraps the whole walk, unused counters included.
		if (fin) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				cnt_next[d] = '0;
			end
		end
		status.boundary = bnd;
		status.final_pt = fin;
	end

endmodule

[sv/grid_ghost_index_generator_top.sv]
// Top level of the grid ghost index generator: registers, handshakes and result register.
`timescale 1ns / 1ps

// Each accepted input item advances the walk over an N-dimensional grid by one point, in
// row-major order with dimension 0 fastest, and yields one output item carrying the point's
// linear index when that point lies on the outer boundary layer, none otherwise. The final
// point of the grid is always a boundary point and carries tlast; the walk then wraps to
// point 0, and a set restart bit returns it to point 0 before the step. The coordinate
// counters and their carry chain update in the cycle the item is accepted, and one result
// register holds the output, so an item is accepted in every cycle as long as that
// register is empty or being drained. Configuration writes take effect from the next
// item on and do not restart the walk.

module grid_ghost_index_generator_top #(
	parameter int MAX_DIMS   = ggig_pkg::MAX_DIMS_DEF,
	parameter int COORD_BITS = ggig_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] restart, [7:1] zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ggig_pkg::INDEX_W-1:0]  m_tdata,   // [47:0] ghost_index
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [ggig_pkg::ADDR_W-1:0]   cfg_addr,
	input  logic [ggig_pkg::CFG_W-1:0]    cfg_data
);
	import ggig_pkg::*;

	logic [DIMS_W-1:0]     num_dims_q;
	logic [SIZE_W-1:0]     dim_size_q [SIZE_REGS];
	logic [COORD_BITS-1:0] cnt_q [MAX_DIMS];
	logic [COORD_BITS-1:0] cnt_eff [MAX_DIMS];
	logic [COORD_BITS-1:0] cnt_next [MAX_DIMS];
	logic [INDEX_W-1:0]    point_idx_q;
	logic [INDEX_W-1:0]    idx_eff;
	logic                  m_valid_q;
	logic [INDEX_W-1:0]    m_data_q;
	logic                  m_last_q;
	logic                  restart;
	logic                  acc;
	step_status_t          st;

	assign restart  = s_tdata[0];
	assign s_tready = !m_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	// A restart presents point 0 to the step logic.
	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			cnt_eff[d] = restart ? '0 : cnt_q[d];
		end
		idx_eff = restart ? '0 : point_idx_q;
	end

	ggig_step #(
		.MAX_DIMS   (MAX_DIMS),
		.COORD_BITS (COORD_BITS)
	) u_step (
		.cnt      (cnt_eff),
		.num_dims (num_dims_q),
		.dim_size (dim_size_q),
		.cnt_next (cnt_next),
		.status   (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= NUM_DIMS_RST;
			for (int i = 0; i < SIZE_REGS; i++) begin
				dim_size_q[i] <= DIM_SIZE_RST;
			end
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_NUM_DIMS:   num_dims_q    <= cfg_data[DIMS_W-1:0];
				CFG_DIM_SIZE_0: dim_size_q[0] <= cfg_data;
				CFG_DIM_SIZE_1: dim_size_q[1] <= cfg_data;
				CFG_DIM_SIZE_2: dim_size_q[2] <= cfg_data;
				CFG_DIM_SIZE_3: dim_size_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				cnt_q[d] <= '0;
			end
			point_idx_q <= '0;
		end else if (acc) begin
			cnt_q       <= cnt_next;
			point_idx_q <= st.final_pt ? '0 : idx_eff + INDEX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (acc) begin
			m_valid_q <= st.boundary;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && st.boundary) begin
			m_data_q <= idx_eff;
			m_last_q <= st.final_pt;
		end
	end

	// Point 0 is always a boundary point, so a restart always yields index 0.
	a_restart_emits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && restart |=> m_tvalid && (m_tdata == '0))
		else $error("restart did not emit index 0");

	a_final_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		acc && st.final_pt |=> (point_idx_q == '0) && (cnt_q[0] == '0))
		else $error("walk did not wrap after the final point");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !restart && !st.final_pt |=>
		(point_idx_q - $past(point_idx_q)) == INDEX_W'(1))
		else $error("point index did not advance by one");

	a_boundary_emits: assert property (@(posedge clk) disable iff (!arst_n)
		acc && st.boundary |=> m_tvalid && (m_tlast == $past(st.final_pt)))
		else $error("boundary point produced no result");

endmodule
